// ===== sv/dspc_pkg.sv =====
package dspc_pkg;

   localparam int TEMP_W = 12;
   localparam int DUTY_W = 8;

   // multiply-add unit widths
   localparam int MAC_A_W = 14;
   localparam int MAC_B_W = 9;
   localparam int MAC_R_W = MAC_A_W + MAC_B_W + 1;

   // item modes
   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_ADJUST = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   // manual adjust targets
   localparam logic [1:0] CH_PELT_A = 2'd0;
   localparam logic [1:0] CH_PELT_B = 2'd1;
   localparam logic [1:0] CH_FAN_A  = 2'd2;
   localparam logic [1:0] CH_FAN_B  = 2'd3;

   // csr indexes
   localparam logic [1:0] REG_HIGH_LIMIT  = 2'd0;
   localparam logic [1:0] REG_LOW_LIMIT   = 2'd1;
   localparam logic [1:0] REG_TARGET_TEMP = 2'd2;
   localparam logic [1:0] REG_AUTO_MODE   = 2'd3;

   localparam logic signed [TEMP_W-1:0] VALID_ABOVE = -12'sd1600;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX    = 12'sd2047;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN    = -12'sd2048;

   localparam logic [DUTY_W-1:0] DUTY_STEP = 8'd25;
   localparam logic [DUTY_W-1:0] DUTY_MAX  = 8'd255;
   localparam logic [DUTY_W-1:0] FAN_BASE  = 8'd76;
   localparam logic [DUTY_W-1:0] FAN_RESET = 8'd128;

   localparam logic signed [MAC_B_W-1:0] GAIN_TARGET = -9'sd2;
   localparam logic signed [MAC_B_W-1:0] GAIN_ERR    = 9'sd25;
   localparam logic signed [MAC_B_W-1:0] GAIN_FAN    = 9'sd179;
   localparam int ERR_SHIFT = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_SCALE,
      ST_CLAMP,
      ST_FAN_MUL,
      ST_FAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic err;
      logic scale;
      logic clamp;
      logic fan_mul;
      logic fan;
   } ctrl_type;

endpackage

// ===== sv/dspc_mac.sv =====
module dspc_mac (
   input  logic signed [dspc_pkg::MAC_A_W-1:0] op_a,
   input  logic signed [dspc_pkg::MAC_B_W-1:0] op_b,
   input  logic signed [dspc_pkg::MAC_A_W-1:0] op_c,
   output logic signed [dspc_pkg::MAC_R_W-1:0] result
);

   logic signed [dspc_pkg::MAC_R_W-1:0] product;

   // a*b + c, all signed
   always_comb begin
      product = dspc_pkg::MAC_R_W'(op_a) * dspc_pkg::MAC_R_W'(op_b);
      result  = product + dspc_pkg::MAC_R_W'(op_c);
   end

endmodule

// ===== sv/dspc_seq.sv =====
module dspc_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_mode,
   input  logic                rsp_ready,
   output logic                req_ready,
   output logic                rsp_valid,
   output dspc_pkg::ctrl_type  ctrl
);

   dspc_pkg::state_type state_ff;
   dspc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dspc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ctrl      = '0;
      unique case (state_ff)
         dspc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == dspc_pkg::MODE_SAMPLE) begin
                  state_in = dspc_pkg::ST_ERR;
               end else begin
                  state_in = dspc_pkg::ST_RESP;
               end
            end
         end
         dspc_pkg::ST_ERR: begin
            ctrl.err = 1'b1;
            state_in = dspc_pkg::ST_SCALE;
         end
         dspc_pkg::ST_SCALE: begin
            ctrl.scale = 1'b1;
            state_in   = dspc_pkg::ST_CLAMP;
         end
         dspc_pkg::ST_CLAMP: begin
            ctrl.clamp = 1'b1;
            state_in   = dspc_pkg::ST_FAN_MUL;
         end
         dspc_pkg::ST_FAN_MUL: begin
            ctrl.fan_mul = 1'b1;
            state_in     = dspc_pkg::ST_FAN;
         end
         dspc_pkg::ST_FAN: begin
            ctrl.fan = 1'b1;
            state_in = dspc_pkg::ST_RESP;
         end
         dspc_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = dspc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dspc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/dual_sensor_proportional_cooler.sv =====
// two-channel temperature monitor with proportional peltier and fan control.
// temperatures are signed 1/16 degree units; a reading at or below -1600 is
// treated as a disconnected sensor and leaves that channel untouched. every
// request word returns exactly one response word, a snapshot of all state
// after the word is applied. for a sample word, the idle state that accepts
// it latches the readings and min/max, then five steps follow (error sum,
// gain, clamp, fan gain, fan offset), of which the error sum, gain and fan
// gain use a single shared multiply-add unit, then the response state. adjust,
// clear and unused-mode words go straight to the response state, with
// rsp_valid right after the accept edge. a stalled response holds the block
// in the response state until it is taken. the block takes one word at a
// time; req_ready is high only while idle. csr writes are always accepted
// and must only be issued while idle.
module dual_sensor_proportional_cooler (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_mode,
   input  logic signed [dspc_pkg::TEMP_W-1:0]      req_temp_a,
   input  logic signed [dspc_pkg::TEMP_W-1:0]      req_temp_b,
   input  logic [1:0]                              req_channel,
   input  logic                                    req_step_up,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dspc_pkg::TEMP_W-1:0]      rsp_cur_a,
   output logic signed [dspc_pkg::TEMP_W-1:0]      rsp_cur_b,
   output logic signed [dspc_pkg::TEMP_W-1:0]      rsp_lowest_a,
   output logic signed [dspc_pkg::TEMP_W-1:0]      rsp_highest_a,
   output logic signed [dspc_pkg::TEMP_W-1:0]      rsp_lowest_b,
   output logic signed [dspc_pkg::TEMP_W-1:0]      rsp_highest_b,
   output logic                                    rsp_alarm,
   output logic [dspc_pkg::DUTY_W-1:0]             rsp_peltier_a_duty,
   output logic [dspc_pkg::DUTY_W-1:0]             rsp_peltier_b_duty,
   output logic [dspc_pkg::DUTY_W-1:0]             rsp_fan_a_duty,
   output logic [dspc_pkg::DUTY_W-1:0]             rsp_fan_b_duty,
   // csr write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [1:0]                              csr_index,
   input  logic [dspc_pkg::TEMP_W-1:0]             csr_data
);

   localparam int TW = dspc_pkg::TEMP_W;
   localparam int DW = dspc_pkg::DUTY_W;
   localparam int AW = dspc_pkg::MAC_A_W;
   localparam int BW = dspc_pkg::MAC_B_W;
   localparam int RW = dspc_pkg::MAC_R_W;
   localparam int FW = 16;  // fan product width, 255*179 < 2^16
   localparam int ERR_SHIFT_W = dspc_pkg::ERR_SHIFT;

   // config registers
   logic signed [TW-1:0] high_ff, high_in;
   logic signed [TW-1:0] low_ff, low_in;
   logic signed [TW-1:0] target_ff, target_in;
   logic                 auto_ff, auto_in;

   // block state
   logic signed [TW-1:0] cur_a_ff, cur_a_in, cur_b_ff, cur_b_in;
   logic signed [TW-1:0] min_a_ff, min_a_in, max_a_ff, max_a_in;
   logic signed [TW-1:0] min_b_ff, min_b_in, max_b_ff, max_b_in;
   logic                 alarm_ff, alarm_in;
   logic [DW-1:0]        pelt_a_ff, pelt_a_in, pelt_b_ff, pelt_b_in;
   logic [DW-1:0]        fan_a_ff, fan_a_in, fan_b_ff, fan_b_in;

   // working registers of the shared unit
   logic signed [RW-1:0] acc_ff, acc_in;
   logic                 d_pos_ff, d_pos_in;
   logic [DW-1:0]        p_ff, p_in;

   dspc_pkg::ctrl_type   ctrl;
   logic                 req_accept;

   logic signed [AW-1:0] mac_a, mac_c;
   logic signed [BW-1:0] mac_b;
   logic signed [RW-1:0] mac_res;

   logic                 a_ok, b_ok;
   logic signed [RW-ERR_SHIFT_W-1:0] q;
   logic [FW:0]          fan_sum;
   logic [DW-1:0]        fan_val;

   function automatic logic [DW-1:0] step_duty(input logic [DW-1:0] duty, input logic up);
      logic [DW:0] sum;
      sum = {1'b0, duty} + {1'b0, dspc_pkg::DUTY_STEP};
      if (up) begin
         step_duty = sum[DW] ? dspc_pkg::DUTY_MAX : sum[DW-1:0];
      end else begin
         step_duty = (duty < dspc_pkg::DUTY_STEP) ? '0 : duty - dspc_pkg::DUTY_STEP;
      end
   endfunction

   dspc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .rsp_ready (rsp_ready),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   dspc_mac u_mac (
      .op_a   (mac_a),
      .op_b   (mac_b),
      .op_c   (mac_c),
      .result (mac_res)
   );

   assign req_accept = req_valid & req_ready;
   assign csr_ready  = 1'b1;

   assign a_ok = req_temp_a > dspc_pkg::VALID_ABOVE;
   assign b_ok = req_temp_b > dspc_pkg::VALID_ABOVE;

   // operand select for the shared multiply-add
   always_comb begin
      mac_a = '0;
      mac_b = '0;
      mac_c = '0;
      if (ctrl.err) begin
         // d = cur_a + cur_b - 2*target
         mac_a = AW'(target_ff);
         mac_b = dspc_pkg::GAIN_TARGET;
         mac_c = AW'(cur_a_ff) + AW'(cur_b_ff);
      end else if (ctrl.scale) begin
         mac_a = acc_ff[AW-1:0];
         mac_b = dspc_pkg::GAIN_ERR;
      end else if (ctrl.fan_mul) begin
         mac_a = AW'($signed({1'b0, p_ff}));
         mac_b = dspc_pkg::GAIN_FAN;
      end
   end

   // floor(d*25/32), d known positive when used
   assign q = acc_ff[RW-1:ERR_SHIFT_W];

   // x/255 as (x + x/256 + 1)/256, exact for 16 bit x
   assign fan_sum = {1'b0, acc_ff[FW-1:0]} + (FW+1)'(acc_ff[FW-1:8]) + (FW+1)'(1);
   assign fan_val = dspc_pkg::FAN_BASE + fan_sum[FW-1:8];

   always_comb begin
      high_in   = high_ff;
      low_in    = low_ff;
      target_in = target_ff;
      auto_in   = auto_ff;
      cur_a_in  = cur_a_ff;
      cur_b_in  = cur_b_ff;
      min_a_in  = min_a_ff;
      max_a_in  = max_a_ff;
      min_b_in  = min_b_ff;
      max_b_in  = max_b_ff;
      alarm_in  = alarm_ff;
      pelt_a_in = pelt_a_ff;
      pelt_b_in = pelt_b_ff;
      fan_a_in  = fan_a_ff;
      fan_b_in  = fan_b_ff;
      acc_in    = acc_ff;
      d_pos_in  = d_pos_ff;
      p_in      = p_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dspc_pkg::REG_HIGH_LIMIT:  high_in   = csr_data;
            dspc_pkg::REG_LOW_LIMIT:   low_in    = csr_data;
            dspc_pkg::REG_TARGET_TEMP: target_in = csr_data;
            dspc_pkg::REG_AUTO_MODE:   auto_in   = csr_data[0];
            default: ;
         endcase
      end

      if (req_accept) begin
         case (req_mode)
            dspc_pkg::MODE_SAMPLE: begin
               // latch valid readings and track extremes
               if (a_ok) begin
                  cur_a_in = req_temp_a;
                  if (req_temp_a < min_a_ff) min_a_in = req_temp_a;
                  if (req_temp_a > max_a_ff) max_a_in = req_temp_a;
               end
               if (b_ok) begin
                  cur_b_in = req_temp_b;
                  if (req_temp_b < min_b_ff) min_b_in = req_temp_b;
                  if (req_temp_b > max_b_ff) max_b_in = req_temp_b;
               end
            end
            dspc_pkg::MODE_ADJUST: begin
               if (!auto_ff) begin
                  case (req_channel)
                     dspc_pkg::CH_PELT_A: pelt_a_in = step_duty(pelt_a_ff, req_step_up);
                     dspc_pkg::CH_PELT_B: pelt_b_in = step_duty(pelt_b_ff, req_step_up);
                     dspc_pkg::CH_FAN_A:  fan_a_in  = step_duty(fan_a_ff, req_step_up);
                     default:             fan_b_in  = step_duty(fan_b_ff, req_step_up);
                  endcase
               end
            end
            dspc_pkg::MODE_CLEAR: begin
               min_a_in = cur_a_ff;
               max_a_in = cur_a_ff;
               min_b_in = cur_b_ff;
               max_b_in = cur_b_ff;
            end
            default: ;
         endcase
      end

      // alarm on the freshly latched readings, error sum into the accumulator
      if (ctrl.err) begin
         alarm_in = (cur_a_ff > high_ff) || (cur_b_ff > high_ff) ||
                    (cur_a_ff < low_ff) || (cur_b_ff < low_ff);
         acc_in   = mac_res;
      end

      if (ctrl.scale) begin
         d_pos_in = acc_ff > 0;
         acc_in   = mac_res;
      end

      // peltier duty: zero when not positive, else clamp to full scale
      if (ctrl.clamp) begin
         if (!d_pos_ff) begin
            p_in = '0;
         end else if (q > $signed((RW-ERR_SHIFT_W)'(dspc_pkg::DUTY_MAX))) begin
            p_in = dspc_pkg::DUTY_MAX;
         end else begin
            p_in = q[DW-1:0];
         end
         if (auto_ff) begin
            pelt_a_in = p_in;
            pelt_b_in = p_in;
         end
      end

      if (ctrl.fan_mul) begin
         acc_in = mac_res;
      end

      // in auto mode fan duty follows the peltier duty with a floor of the base speed, zero while the peltier is off
      if (ctrl.fan && auto_ff) begin
         fan_a_in = (p_ff != '0) ? fan_val : '0;
         fan_b_in = (p_ff != '0) ? fan_val : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff   <= 12'sd640;
         low_ff    <= 12'sd80;
         target_ff <= 12'sd400;
         auto_ff   <= 1'b1;
         cur_a_ff  <= '0;
         cur_b_ff  <= '0;
         min_a_ff  <= dspc_pkg::TEMP_MAX;
         max_a_ff  <= dspc_pkg::TEMP_MIN;
         min_b_ff  <= dspc_pkg::TEMP_MAX;
         max_b_ff  <= dspc_pkg::TEMP_MIN;
         alarm_ff  <= 1'b0;
         pelt_a_ff <= '0;
         pelt_b_ff <= '0;
         fan_a_ff  <= dspc_pkg::FAN_RESET;
         fan_b_ff  <= dspc_pkg::FAN_RESET;
      end else begin
         high_ff   <= high_in;
         low_ff    <= low_in;
         target_ff <= target_in;
         auto_ff   <= auto_in;
         cur_a_ff  <= cur_a_in;
         cur_b_ff  <= cur_b_in;
         min_a_ff  <= min_a_in;
         max_a_ff  <= max_a_in;
         min_b_ff  <= min_b_in;
         max_b_ff  <= max_b_in;
         alarm_ff  <= alarm_in;
         pelt_a_ff <= pelt_a_in;
         pelt_b_ff <= pelt_b_in;
         fan_a_ff  <= fan_a_in;
         fan_b_ff  <= fan_b_in;
      end
   end

   // datapath scratch, no reset needed
   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      d_pos_ff <= d_pos_in;
      p_ff     <= p_in;
   end

   // response word is the live state, held still while waiting in the resp state
   assign rsp_cur_a          = cur_a_ff;
   assign rsp_cur_b          = cur_b_ff;
   assign rsp_lowest_a       = min_a_ff;
   assign rsp_highest_a      = max_a_ff;
   assign rsp_lowest_b       = min_b_ff;
   assign rsp_highest_b      = max_b_ff;
   assign rsp_alarm          = alarm_ff;
   assign rsp_peltier_a_duty = pelt_a_ff;
   assign rsp_peltier_b_duty = pelt_b_ff;
   assign rsp_fan_a_duty     = fan_a_ff;
   assign rsp_fan_b_duty     = fan_b_ff;

endmodule
